// ===== rtl/ewma_pkg.sv =====
`timescale 1ns / 1ps
package ewma_pkg;

	localparam int SAMPLE_BITS_DEF   = 16;
	localparam int FRACTION_BITS_DEF = 16;
	localparam int AVG_BITS          = 32;
	localparam int UNIT_BITS         = 16;
	localparam int NORM_BITS         = 14;
	localparam int UNIT_OUT_BITS     = 17;
	localparam int CENT_OUT_BITS     = 15;
	localparam int NORM_OUT_BITS     = 16;
	localparam int CFG_INDEX_BITS    = 2;
	localparam int CFG_DATA_BITS     = 32;
	localparam int FROZEN_FS_BITS    = 31;
	localparam int LENGTH_BITS       = 16;

	localparam logic [CFG_INDEX_BITS-1:0] REG_AVG_LENGTH    = 2'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FREEZE_BOUNDS = 2'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FROZEN_BIAS   = 2'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_FROZEN_FS     = 2'd3;

	localparam logic [1:0] CHG_NONE = 2'd0;
	localparam logic [1:0] CHG_MAX  = 2'd1;
	localparam logic [1:0] CHG_MIN  = 2'd2;

	typedef enum logic [1:0] {
		OP_AVG,
		OP_NORM,
		OP_UNIT,
		OP_CENT
	} op_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RANGE,
		ST_START,
		ST_WAIT,
		ST_OUT
	} state_t;

	typedef struct packed {
		logic capture;
		logic range_upd;
		logic div_start;
		logic store;
		logic load_out;
		op_t  op;
	} cmd_t;

	typedef struct packed {
		logic div_busy;
	} status_t;

endpackage

// ===== rtl/ewma_with_range_tracking.sv =====
`timescale 1ns / 1ps
// Running average (Q16.16) with min/max tracking and scaled outputs. One request is
// processed at a time: the sample is captured, the range is updated, then four
// divisions run in turn on one shared restoring divider (average step, normalized average, unit
// position, centred position). A finished result sits in an output register, and the
// next request is taken while it waits. Config writes are always ready and are to be
// issued only while the block is idle.
module ewma_with_range_tracking #(
	parameter int SAMPLE_BITS   = ewma_pkg::SAMPLE_BITS_DEF,
	parameter int FRACTION_BITS = ewma_pkg::FRACTION_BITS_DEF
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  logic                                       cfg_valid,
	output logic                                       cfg_ready,
	input  logic [ewma_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [ewma_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	input  logic                                       in_valid,
	output logic                                       in_ready,
	input  logic signed [SAMPLE_BITS-1:0]              sample,
	output logic                                       out_valid,
	input  logic                                       out_ready,
	output logic signed [ewma_pkg::AVG_BITS-1:0]       average,
	output logic signed [SAMPLE_BITS-1:0]              minimum,
	output logic signed [SAMPLE_BITS-1:0]              maximum,
	output logic        [SAMPLE_BITS-1:0]              span,
	output logic        [1:0]                          change_kind,
	output logic        [ewma_pkg::UNIT_OUT_BITS-1:0]  unit_position,
	output logic signed [ewma_pkg::CENT_OUT_BITS-1:0]  centred_position,
	output logic signed [ewma_pkg::NORM_OUT_BITS-1:0]  normalized_average
);
	import ewma_pkg::*;

	localparam int BASE_BITS = (SAMPLE_BITS + FRACTION_BITS + 1 > AVG_BITS) ?
	                           SAMPLE_BITS + FRACTION_BITS + 1 : AVG_BITS;
	localparam int NUM_BITS  = BASE_BITS + NORM_BITS + 1;
	localparam int DEN_BITS  = (SAMPLE_BITS + FRACTION_BITS - 1 > FROZEN_FS_BITS) ?
	                           SAMPLE_BITS + FRACTION_BITS - 1 : FROZEN_FS_BITS;

	cmd_t    cmd;
	status_t status;
	logic signed [NUM_BITS-1:0] div_num;
	logic        [DEN_BITS-1:0] div_den;
	logic signed [NUM_BITS:0]   div_quo;

	assign cfg_ready = 1'b1;

	ewma_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	ewma_div #(
		.NUM_BITS (NUM_BITS),
		.DEN_BITS (DEN_BITS)
	) u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.div_start),
		.num    (div_num),
		.den    (div_den),
		.busy   (status.div_busy),
		.quo    (div_quo)
	);

	ewma_dp #(
		.SAMPLE_BITS   (SAMPLE_BITS),
		.FRACTION_BITS (FRACTION_BITS),
		.NUM_BITS      (NUM_BITS),
		.DEN_BITS      (DEN_BITS)
	) u_dp (
		.clk                (clk),
		.arst_n             (arst_n),
		.cmd                (cmd),
		.cfg_valid          (cfg_valid),
		.cfg_index          (cfg_index),
		.cfg_data           (cfg_data),
		.sample             (sample),
		.div_quo            (div_quo),
		.div_num            (div_num),
		.div_den            (div_den),
		.average            (average),
		.minimum            (minimum),
		.maximum            (maximum),
		.span               (span),
		.change_kind        (change_kind),
		.unit_position      (unit_position),
		.centred_position   (centred_position),
		.normalized_average (normalized_average)
	);

endmodule

// ===== rtl/ewma_div.sv =====
`timescale 1ns / 1ps
module ewma_div #(
	parameter int NUM_BITS = 48,
	parameter int DEN_BITS = 31
) (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic signed [NUM_BITS-1:0] num,
	input  logic        [DEN_BITS-1:0] den,
	output logic                       busy,
	output logic signed [NUM_BITS:0]   quo
);
	localparam int CNT_BITS = $clog2(NUM_BITS + 1);

	logic [DEN_BITS:0]   rem_q;
	logic [NUM_BITS-1:0] quo_q;
	logic [DEN_BITS-1:0] den_q;
	logic [CNT_BITS-1:0] cnt_q;
	logic                neg_q;
	logic                busy_q;
	logic [DEN_BITS:0]   sh;
	logic [DEN_BITS+1:0] trial;

	assign sh    = {rem_q[DEN_BITS-1:0], quo_q[NUM_BITS-1]};
	assign trial = {1'b0, sh} - {2'b00, den_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= CNT_BITS'(NUM_BITS);
		end else if (busy_q) begin
			cnt_q <= cnt_q - 1'b1;
			if (cnt_q == CNT_BITS'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// restoring divide, one quotient bit per cycle
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= num[NUM_BITS-1] ? (~num + 1'b1) : num;
			den_q <= den;
			neg_q <= num[NUM_BITS-1];
		end else if (busy_q) begin
			if (!trial[DEN_BITS+1]) begin
				rem_q <= trial[DEN_BITS:0];
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b1};
			end else begin
				rem_q <= sh;
				quo_q <= {quo_q[NUM_BITS-2:0], 1'b0};
			end
		end
	end

	assign busy = busy_q;
	assign quo  = neg_q ? -$signed({1'b0, quo_q}) : $signed({1'b0, quo_q});

endmodule

// ===== rtl/ewma_dp.sv =====
`timescale 1ns / 1ps
module ewma_dp #(
	parameter int SAMPLE_BITS   = 16,
	parameter int FRACTION_BITS = 16,
	parameter int NUM_BITS      = 48,
	parameter int DEN_BITS      = 31
) (
	input  logic                                       clk,
	input  logic                                       arst_n,
	input  ewma_pkg::cmd_t                             cmd,
	input  logic                                       cfg_valid,
	input  logic [ewma_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
	input  logic [ewma_pkg::CFG_DATA_BITS-1:0]         cfg_data,
	input  logic signed [SAMPLE_BITS-1:0]              sample,
	input  logic signed [NUM_BITS:0]                   div_quo,
	output logic signed [NUM_BITS-1:0]                 div_num,
	output logic        [DEN_BITS-1:0]                 div_den,
	output logic signed [ewma_pkg::AVG_BITS-1:0]       average,
	output logic signed [SAMPLE_BITS-1:0]              minimum,
	output logic signed [SAMPLE_BITS-1:0]              maximum,
	output logic        [SAMPLE_BITS-1:0]              span,
	output logic        [1:0]                          change_kind,
	output logic        [ewma_pkg::UNIT_OUT_BITS-1:0]  unit_position,
	output logic signed [ewma_pkg::CENT_OUT_BITS-1:0]  centred_position,
	output logic signed [ewma_pkg::NORM_OUT_BITS-1:0]  normalized_average
);
	import ewma_pkg::*;

	localparam int SB = SAMPLE_BITS;
	localparam int FB = FRACTION_BITS;

	logic [LENGTH_BITS-1:0]    len_q;
	logic                      freeze_q;
	logic signed [AVG_BITS-1:0] fbias_q;
	logic [FROZEN_FS_BITS-1:0] ffs_q;

	logic signed [SB-1:0]       sample_q;
	logic signed [SB-1:0]       hi_q, lo_q;
	logic                       any_q;
	logic [1:0]                 chg_q;
	logic signed [SB+1:0]       dbias_q;
	logic [SB:0]                dfs_q;
	logic signed [AVG_BITS-1:0] avg_q;
	logic signed [CENT_OUT_BITS-1:0] cent_q;
	logic [UNIT_OUT_BITS-1:0]   unit_q;
	logic signed [NORM_OUT_BITS-1:0] norm_q;

	logic signed [AVG_BITS-1:0] out_avg_q;
	logic signed [SB-1:0]       out_lo_q, out_hi_q;
	logic [SB-1:0]              out_span_q;
	logic [1:0]                 out_chg_q;
	logic [UNIT_OUT_BITS-1:0]   out_unit_q;
	logic signed [CENT_OUT_BITS-1:0] out_cent_q;
	logic signed [NORM_OUT_BITS-1:0] out_norm_q;

	logic signed [SB-1:0]   hi_n, lo_n;
	logic [1:0]             chg_n;
	logic signed [SB:0]     span_raw_n, span_raw;
	logic [SB-1:0]          span_n, span_c;
	logic signed [NUM_BITS-1:0] d_ext, x_ext, bias_ext;
	logic signed [NUM_BITS+1:0] avg_sum;
	logic [NUM_BITS+2-AVG_BITS:0] avg_top;
	logic [NUM_BITS+1-NORM_OUT_BITS:0] norm_top;

	// range update from the captured sample
	always_comb begin
		hi_n  = hi_q;
		lo_n  = lo_q;
		chg_n = CHG_NONE;
		if (!any_q || sample_q > hi_q) begin
			hi_n  = sample_q;
			chg_n = CHG_MAX;
		end
		if (!any_q || sample_q < lo_q) begin
			lo_n  = sample_q;
			chg_n = CHG_MIN;
		end
		span_raw_n = (SB+1)'(hi_n) - (SB+1)'(lo_n);
		span_n     = (span_raw_n == '0) ? SB'(1) : span_raw_n[SB-1:0];
		span_raw   = (SB+1)'(hi_q) - (SB+1)'(lo_q);
		span_c     = (span_raw == '0) ? SB'(1) : span_raw[SB-1:0];
	end

	always_comb begin
		d_ext    = NUM_BITS'(sample_q) - NUM_BITS'(lo_q);
		x_ext    = (d_ext <<< 1) - $signed(NUM_BITS'({1'b0, span_c}));
		bias_ext = freeze_q ? NUM_BITS'(fbias_q) : (NUM_BITS'(dbias_q) <<< (FB - 1));
		div_num  = '0;
		div_den  = DEN_BITS'(1);
		case (cmd.op)
			OP_AVG: begin
				div_num = (NUM_BITS'(sample_q) <<< FB) - NUM_BITS'(avg_q);
				div_den = (len_q == '0) ? DEN_BITS'(1) : DEN_BITS'(len_q);
			end
			OP_NORM: begin
				div_num = (NUM_BITS'(avg_q) + bias_ext) <<< NORM_BITS;
				if (freeze_q) begin
					div_den = (ffs_q == '0) ? DEN_BITS'(1) : DEN_BITS'(ffs_q);
				end else begin
					div_den = DEN_BITS'(dfs_q) << (FB - 1);
				end
			end
			OP_UNIT: begin
				div_num = d_ext <<< UNIT_BITS;
				div_den = DEN_BITS'(span_c);
			end
			OP_CENT: begin
				// times 32767 as a shift and subtract
				div_num = (x_ext <<< 15) - x_ext;
				div_den = DEN_BITS'(span_c) << 1;
			end
			default: begin
				div_num = '0;
				div_den = DEN_BITS'(1);
			end
		endcase
		avg_sum  = (NUM_BITS+2)'(avg_q) + (NUM_BITS+2)'(div_quo);
		avg_top  = avg_sum[NUM_BITS+1:AVG_BITS-1];
		norm_top = (NUM_BITS+2-NORM_OUT_BITS)'(div_quo[NUM_BITS:NORM_OUT_BITS-1]);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q    <= LENGTH_BITS'(16);
			freeze_q <= 1'b0;
			fbias_q  <= '0;
			ffs_q    <= FROZEN_FS_BITS'(65536);
			any_q    <= 1'b0;
			hi_q     <= '0;
			lo_q     <= '0;
			dbias_q  <= '0;
			dfs_q    <= (SB+1)'(1);
			avg_q    <= '0;
		end else begin
			if (cfg_valid) begin
				case (cfg_index)
					REG_AVG_LENGTH:    len_q    <= cfg_data[LENGTH_BITS-1:0];
					REG_FREEZE_BOUNDS: freeze_q <= cfg_data[0];
					REG_FROZEN_BIAS:   fbias_q  <= $signed(cfg_data);
					REG_FROZEN_FS:     ffs_q    <= cfg_data[FROZEN_FS_BITS-1:0];
					default:           len_q    <= len_q;
				endcase
			end
			if (cmd.range_upd) begin
				any_q <= 1'b1;
				hi_q  <= hi_n;
				lo_q  <= lo_n;
				if (chg_n != CHG_NONE && !freeze_q) begin
					dbias_q <= -((SB+2)'(hi_n) + (SB+2)'(lo_n));
					dfs_q   <= (SB+1)'(span_n);
				end
			end
			if (cmd.store && cmd.op == OP_AVG) begin
				if (&avg_top || ~|avg_top) begin
					avg_q <= avg_sum[AVG_BITS-1:0];
				end else begin
					avg_q <= avg_sum[NUM_BITS+1] ? {1'b1, {(AVG_BITS-1){1'b0}}}
					                             : {1'b0, {(AVG_BITS-1){1'b1}}};
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			sample_q <= sample;
		end
		if (cmd.range_upd) begin
			chg_q <= chg_n;
		end
		if (cmd.store) begin
			case (cmd.op)
				OP_NORM: begin
					if (&norm_top || ~|norm_top) begin
						norm_q <= div_quo[NORM_OUT_BITS-1:0];
					end else begin
						norm_q <= div_quo[NUM_BITS] ? {1'b1, {(NORM_OUT_BITS-1){1'b0}}}
						                            : {1'b0, {(NORM_OUT_BITS-1){1'b1}}};
					end
				end
				OP_UNIT: unit_q <= div_quo[UNIT_OUT_BITS-1:0];
				OP_CENT: cent_q <= div_quo[CENT_OUT_BITS-1:0];
				default: unit_q <= unit_q;
			endcase
		end
		if (cmd.load_out) begin
			out_avg_q  <= avg_q;
			out_lo_q   <= lo_q;
			out_hi_q   <= hi_q;
			out_span_q <= span_c;
			out_chg_q  <= chg_q;
			out_unit_q <= unit_q;
			out_cent_q <= cent_q;
			out_norm_q <= norm_q;
		end
	end

	assign average            = out_avg_q;
	assign minimum            = out_lo_q;
	assign maximum            = out_hi_q;
	assign span               = out_span_q;
	assign change_kind        = out_chg_q;
	assign unit_position      = out_unit_q;
	assign centred_position   = out_cent_q;
	assign normalized_average = out_norm_q;

endmodule

// ===== rtl/ewma_ctrl.sv =====
`timescale 1ns / 1ps
module ewma_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  ewma_pkg::status_t status,
	output ewma_pkg::cmd_t    cmd
);
	import ewma_pkg::*;

	state_t state_q, state_d;
	op_t    op_q, op_d;
	logic   out_valid_q;

	always_comb begin
		state_d = state_q;
		op_d    = op_q;
		case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					state_d = ST_RANGE;
				end
			end
			ST_RANGE: begin
				state_d = ST_START;
				op_d    = OP_AVG;
			end
			ST_START: state_d = ST_WAIT;
			ST_WAIT: begin
				if (!status.div_busy) begin
					case (op_q)
						OP_AVG:  begin op_d = OP_NORM; state_d = ST_START; end
						OP_NORM: begin op_d = OP_UNIT; state_d = ST_START; end
						OP_UNIT: begin op_d = OP_CENT; state_d = ST_START; end
						default: state_d = ST_OUT;
					endcase
				end
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd           = '0;
		cmd.op        = op_q;
		cmd.capture   = (state_q == ST_IDLE) && in_valid;
		cmd.range_upd = (state_q == ST_RANGE);
		cmd.div_start = (state_q == ST_START);
		cmd.store     = (state_q == ST_WAIT) && !status.div_busy;
		cmd.load_out  = (state_q == ST_OUT) && (!out_valid_q || out_ready);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			op_q        <= OP_AVG;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			op_q    <= op_d;
			if (cmd.load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = out_valid_q;

`ifndef SYNTHESIS
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.load_out |-> (!out_valid_q || out_ready))
		else $error("result overwritten before taken");
	a_accept_to_range: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> (state_q == ST_RANGE))
		else $error("accepted request not processed");
	a_start_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_START) |=> status.div_busy)
		else $error("divider did not start");
`endif

endmodule

// ===== tb/ewma_with_range_tracking_test.sv =====
`timescale 1ns / 1ps
module ewma_with_range_tracking_test;
	import ewma_pkg::*;

	typedef struct packed {
		logic signed [31:0] avg;
		logic signed [15:0] lo;
		logic signed [15:0] hi;
		logic [15:0]        spn;
		logic [1:0]         chg;
		logic [16:0]        unit_pos;
		logic signed [14:0] cent_pos;
		logic signed [15:0] norm_avg;
	} stats_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_valid = 1'b0;
	logic cfg_ready;
	logic [CFG_INDEX_BITS-1:0] cfg_index = REG_AVG_LENGTH;
	logic [CFG_DATA_BITS-1:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic signed [15:0] sample = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	logic signed [31:0] average;
	logic signed [15:0] minimum, maximum;
	logic [15:0] span;
	logic [1:0] change_kind;
	logic [16:0] unit_position;
	logic signed [14:0] centred_position;
	logic signed [15:0] normalized_average;

	ewma_with_range_tracking dut (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// shadow of block config and state
	logic [15:0] len_reg = 16'd16;
	logic freeze_reg = 1'b0;
	logic signed [31:0] fbias_reg = '0;
	logic [30:0] ffs_reg = 31'd65536;
	longint run_avg = 0, lo_seen = 0, hi_seen = 0, dbias = 0, dfs = 1;
	bit seen_any = 0;

	logic signed [15:0] pending_samples[$];
	stats_t expected_stats[$];
	int mismatches = 0, results_seen = 0, requests_sent = 0;
	bit sender_hold = 1'b0;

	function automatic longint clip(longint v, longint lo, longint hi);
		return v < lo ? lo : (v > hi ? hi : v);
	endfunction

	function automatic stats_t track_sample(logic signed [15:0] s_in);
		stats_t r;
		longint s, len, spn, diff, bq, fq, num;
		int chg;
		s = s_in;
		len = (len_reg == 0) ? 1 : len_reg;
		chg = CHG_NONE;
		if (!seen_any || s > hi_seen) begin
			hi_seen = s;
			chg = CHG_MAX;
		end
		if (!seen_any || s < lo_seen) begin
			lo_seen = s;
			chg = CHG_MIN;
		end
		seen_any = 1;
		spn = hi_seen - lo_seen;
		if (spn == 0) spn = 1;
		if (chg != CHG_NONE && !freeze_reg) begin
			dbias = -(hi_seen + lo_seen);
			dfs = spn;
		end
		diff = s * 65536 - run_avg;
		run_avg = clip(run_avg + diff / len, -64'sd2147483648, 64'sd2147483647);
		if (freeze_reg) begin
			bq = fbias_reg;
			fq = (ffs_reg == 0) ? 1 : ffs_reg;
		end else begin
			bq = dbias * 32768;
			fq = dfs * 32768;
			if (fq <= 0) fq = 1;
		end
		num = (run_avg + bq) * 16384;
		r.avg = run_avg;
		r.lo = lo_seen;
		r.hi = hi_seen;
		r.spn = spn;
		r.chg = chg;
		diff = s - lo_seen;
		r.unit_pos = (diff * 65536) / spn;
		r.cent_pos = ((2 * diff - spn) * 32767) / (2 * spn);
		r.norm_avg = clip(num / fq, -32768, 32767);
		return r;
	endfunction

	// sender: bursts with random gaps
	int burst_left = 0, gap_left = 0;
	always @(posedge clk) begin : sender
		logic nv;
		if (arst_n) begin
			nv = in_valid;
			if (in_valid && in_ready) begin
				expected_stats.push_back(track_sample(sample));
				void'(pending_samples.pop_front());
				requests_sent++;
				nv = 1'b0;
			end
			if (!nv) begin
				if (burst_left == 0) begin
					burst_left = $urandom_range(1, 60);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
				end
				if (gap_left > 0)
					gap_left--;
				else if (!sender_hold && pending_samples.size() > 0) begin
					nv = 1'b1;
					sample <= pending_samples[0];
					burst_left--;
				end
			end
			in_valid <= nv;
		end
	end

	task automatic check(string name, longint e, longint a);
		if (e != a) begin
			mismatches++;
			if (mismatches <= 10)
				$display("MISMATCH result %0d %s: expected %0d got %0d",
					results_seen, name, e, a);
		end
	endtask

	// receiver: stall pattern plus one long hold-off
	int stall_mode = 0, mode_left = 0, hold_left = 0;
	bit hold_done = 0;
	always @(posedge clk) begin : receiver
		stats_t e;
		logic nr;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (expected_stats.size() == 0) begin
					mismatches++;
					if (mismatches <= 10) $display("MISMATCH unexpected result");
				end else begin
					e = expected_stats.pop_front();
					check("average", e.avg, average);
					check("minimum", e.lo, minimum);
					check("maximum", e.hi, maximum);
					check("span", e.spn, span);
					check("change_kind", e.chg, change_kind);
					check("unit_position", e.unit_pos, unit_position);
					check("centred_position", e.cent_pos, centred_position);
					check("normalized_average", e.norm_avg, normalized_average);
				end
				results_seen++;
				if (results_seen == 400 && !hold_done) begin
					hold_done = 1;
					hold_left = 3000;
				end
			end
			if (mode_left == 0) begin
				stall_mode = $urandom_range(0, 2);
				mode_left = $urandom_range(50, 600);
			end
			mode_left--;
			if (hold_left > 0) begin
				hold_left--;
				nr = 1'b0;
			end else case (stall_mode)
				0: nr = 1'b1;
				1: nr = 1'($urandom_range(0, 1));
				default: nr = ($urandom_range(0, 3) == 0);
			endcase
			out_ready <= nr;
		end
	end

	task automatic cfg_write(logic [CFG_INDEX_BITS-1:0] idx, logic [31:0] val);
		@(posedge clk);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data <= val;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		case (idx)
			REG_AVG_LENGTH: len_reg = val[15:0];
			REG_FREEZE_BOUNDS: freeze_reg = val[0];
			REG_FROZEN_BIAS: fbias_reg = val;
			default: ffs_reg = val[30:0];
		endcase
	endtask

	task automatic drain;
		while (pending_samples.size() > 0 || in_valid || expected_stats.size() > 0)
			@(posedge clk);
		repeat (250) @(posedge clk);
	endtask

	task automatic random_phase(int n);
		int pick;
		for (int i = 0; i < n; i++) begin
			pick = $urandom_range(0, 9);
			if (pick < 5)
				pending_samples.push_back(16'($urandom));
			else if (pick < 8)
				pending_samples.push_back(16'(int'($urandom_range(0, 200)) - 100));
			else
				pending_samples.push_back(pick == 8 ? 16'(32'h7fff - $urandom_range(0, 3))
					: 16'(32'h8000 + $urandom_range(0, 3)));
		end
	endtask

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
		// bounds frozen from the first sample, zero length and zero full scale
		cfg_write(REG_AVG_LENGTH, 32'd0);
		cfg_write(REG_FREEZE_BOUNDS, 32'd1);
		cfg_write(REG_FROZEN_BIAS, 32'h7fff_ffff);
		cfg_write(REG_FROZEN_FS, 32'd0);
		pending_samples = '{16'sd5, 16'sd5, 16'sd3, 16'sd9, -16'sd1, 16'sd0};
		drain();
		cfg_write(REG_FREEZE_BOUNDS, 32'd0);
		cfg_write(REG_AVG_LENGTH, 32'd1);
		pending_samples = '{16'sh7fff, -16'sh8000, 16'sd0, 16'sh7fff, -16'sh8000,
			-16'sd1, 16'sd1, 16'sh5555, -16'sh5556, 16'sd0};
		drain();
		cfg_write(REG_AVG_LENGTH, 32'd65535);
		pending_samples = '{16'sh7fff, 16'sh7fff, -16'sh8000, 16'sd100};
		drain();
		// random phases over several settings; each drain pauses the sender fully
		for (int ph = 0; ph < 6; ph++) begin
			case (ph)
				0: cfg_write(REG_AVG_LENGTH, 32'd16);
				1: begin
					cfg_write(REG_FREEZE_BOUNDS, 32'd1);
					cfg_write(REG_FROZEN_BIAS, 32'h8000_0000);
					cfg_write(REG_FROZEN_FS, 32'h7fff_ffff);
				end
				2: begin
					cfg_write(REG_FROZEN_BIAS, $urandom);
					cfg_write(REG_FROZEN_FS, 32'd1);
					cfg_write(REG_AVG_LENGTH, $urandom_range(1, 8));
				end
				3: begin
					cfg_write(REG_FREEZE_BOUNDS, 32'd0);
					cfg_write(REG_AVG_LENGTH, 32'd65535);
				end
				4: begin
					cfg_write(REG_FREEZE_BOUNDS, 32'd1);
					cfg_write(REG_FROZEN_FS, $urandom_range(1, 32'h7fff_ffff));
					cfg_write(REG_AVG_LENGTH, $urandom_range(0, 65535));
				end
				default: begin
					cfg_write(REG_FREEZE_BOUNDS, 32'd0);
					cfg_write(REG_AVG_LENGTH, 32'd2);
				end
			endcase
			random_phase(180);
			drain();
		end
		$display("Sent %0d samples, checked %0d results over frozen and tracked bounds,",
			requests_sent, results_seen);
		$display("lengths from 0 to 65535, with sender gaps and receiver stalls.");
		if (mismatches == 0 && expected_stats.size() == 0)
			$display("ewma_with_range_tracking test passed");
		else
			$display("ewma_with_range_tracking test failed");
		$finish;
	end

	initial begin
		#20_000_000;
		$display("ewma_with_range_tracking test failed");
		$finish;
	end

endmodule
